// ----- design/pcrop_pkg.sv -----
// Shared types and register indexes of the cropped stored-PNG encoder.
package pcrop_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_TOP    = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  // One classified pixel word handed from the front part to the back part.
  typedef struct packed {
    logic        hdr;     // open a file: signature, IHDR, IDAT head, zlib header
    logic        pix;     // pixel lies in the rectangle: emit its raw bytes
    logic        filt;    // first pixel of a row: emit the filter byte first
    logic        trl;     // close the file: Adler-32, IDAT CRC, IEND
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] width;   // clamped rectangle size of the open file
    logic [11:0] height;
  } cmd_t;

endpackage

// ----- design/pcrop_front.sv -----
// Front part: position counters, crop registers and pixel classification.
module pcrop_front #(
  parameter int FRAME_WIDTH  = 1920,
  parameter int FRAME_HEIGHT = 1080
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [11:0]       cfg_data,
  input  logic              accept,
  input  logic [7:0]        pixel_blue,
  input  logic [7:0]        pixel_green,
  input  logic [7:0]        pixel_red,
  input  logic              frame_start,
  output logic              push,
  output pcrop_pkg::cmd_t   cmd
);

  localparam logic [12:0] FW = 13'(FRAME_WIDTH);
  localparam logic [12:0] FH = 13'(FRAME_HEIGHT);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_CAPTURE = 3'b010,
    PH_TRAILER = 3'b100
  } phase_t;

  logic [11:0] crop_left, crop_top, crop_width, crop_height;
  logic [11:0] column_count, row_count;
  logic [11:0] used_left, used_top, used_width, used_height;
  phase_t      phase, phase_next;

  logic [12:0] room_w, room_h;
  logic [11:0] new_w, new_h;
  logic        start;
  logic        cap;
  logic [11:0] eff_left, eff_top, eff_w, eff_h;
  logic [11:0] col_eff, row_eff;
  logic [12:0] right_end, bottom_end;
  logic        inrect, last;
  logic [12:0] col_inc, row_inc;
  logic [11:0] column_next, row_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      crop_left   <= '0;
      crop_top    <= '0;
      crop_width  <= 12'd1920;
      crop_height <= 12'd1080;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pcrop_pkg::REG_LEFT:   crop_left   <= cfg_data;
        pcrop_pkg::REG_TOP:    crop_top    <= cfg_data;
        pcrop_pkg::REG_WIDTH:  crop_width  <= cfg_data;
        pcrop_pkg::REG_HEIGHT: crop_height <= cfg_data;
        default:               crop_left   <= crop_left;
      endcase
    end
  end

  // Clamp the requested rectangle to the frame.
  always_comb begin
    room_w = FW - {1'b0, crop_left};
    room_h = FH - {1'b0, crop_top};
    new_w  = '0;
    new_h  = '0;
    if ({1'b0, crop_left} < FW)
      new_w = ({1'b0, crop_width} < room_w) ? crop_width : room_w[11:0];
    if ({1'b0, crop_top} < FH)
      new_h = ({1'b0, crop_height} < room_h) ? crop_height : room_h[11:0];
  end

  always_comb begin
    start      = frame_start && (phase != PH_TRAILER) && new_w != '0 && new_h != '0;
    cap        = frame_start ? start : (phase == PH_CAPTURE);
    eff_left   = start ? crop_left : used_left;
    eff_top    = start ? crop_top  : used_top;
    eff_w      = start ? new_w     : used_width;
    eff_h      = start ? new_h     : used_height;
    col_eff    = frame_start ? '0 : column_count;
    row_eff    = frame_start ? '0 : row_count;
    right_end  = {1'b0, eff_left} + {1'b0, eff_w};
    bottom_end = {1'b0, eff_top} + {1'b0, eff_h};
    inrect     = cap && (phase != PH_TRAILER) &&
                 col_eff >= eff_left && {1'b0, col_eff} < right_end &&
                 row_eff >= eff_top  && {1'b0, row_eff} < bottom_end;
    last       = inrect && ({1'b0, col_eff} == right_end - 13'd1) &&
                 ({1'b0, row_eff} == bottom_end - 13'd1);

    cmd.hdr    = start;
    cmd.pix    = inrect;
    cmd.filt   = (col_eff == eff_left);
    cmd.trl    = (phase == PH_TRAILER) || (last && !start);
    cmd.red    = pixel_red;
    cmd.green  = pixel_green;
    cmd.blue   = pixel_blue;
    cmd.width  = eff_w;
    cmd.height = eff_h;
    push       = accept && (cmd.hdr || cmd.pix || cmd.trl);

    if (phase == PH_TRAILER)
      phase_next = PH_IDLE;
    else if (last)
      phase_next = start ? PH_TRAILER : PH_IDLE;
    else
      phase_next = cap ? PH_CAPTURE : PH_IDLE;

    // Advance the raster position, wrapping at the frame edges.
    col_inc = {1'b0, col_eff} + 13'd1;
    row_inc = {1'b0, row_eff} + 13'd1;
    if (col_inc >= FW) begin
      column_next = '0;
      row_next    = (row_inc >= FH) ? '0 : row_inc[11:0];
    end else begin
      column_next = col_inc[11:0];
      row_next    = row_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      column_count <= '0;
      row_count    <= '0;
      used_left    <= '0;
      used_top     <= '0;
      used_width   <= '0;
      used_height  <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      column_count <= column_next;
      row_count    <= row_next;
      if (start) begin
        used_left   <= crop_left;
        used_top    <= crop_top;
        used_width  <= new_w;
        used_height <= new_h;
      end
    end
  end

endmodule

// ----- design/pcrop_queue.sv -----
// Two-entry queue of classified pixel words between front and back.
module pcrop_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pcrop_pkg::cmd_t push_cmd,
  input  logic            pop,
  output pcrop_pkg::cmd_t head,
  output logic            full,
  output logic            empty
);

  pcrop_pkg::cmd_t slot [2];
  logic            wr_ptr, rd_ptr;
  logic [1:0]      count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/pcrop_back.sv -----
// Back part: byte sequencer with CRC-32, Adler-32 and stored-block framing.
module pcrop_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  pcrop_pkg::cmd_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            run_last,
  output logic            file_end
);

  localparam logic [31:0] CRC_POLY  = 32'hedb88320;
  localparam logic [31:0] CRC_ONES  = 32'hFFFFFFFF;
  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam logic [16:0] BLOCK_MAX = 17'd65535;
  localparam logic [5:0]  HDR_LAST  = 6'd42;
  localparam logic [5:0]  BLK_LAST  = 6'd4;
  localparam logic [5:0]  TRL_LAST  = 6'd19;

  typedef enum logic [3:0] {
    SG_HDR = 4'b0001,
    SG_BLK = 4'b0010,
    SG_RAW = 4'b0100,
    SG_TRL = 4'b1000
  } seg_t;

  function automatic logic [31:0] crc8(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++)
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    return c;
  endfunction

  logic        active;
  seg_t        seg, seg_cur, seg_nx;
  logic [5:0]  idx, idx_cur, idx_nx;
  logic [1:0]  ri, ri_cur, ri_nx;
  logic        done;
  logic [31:0] crc;
  logic [15:0] adler_low, adler_high;
  logic [25:0] raw_rem;
  logic [15:0] blk_rem;

  // Header arithmetic, refreshed every cycle from the queue head.
  logic [25:0] raw_n1, raw_n2, raw_n3;
  logic [9:0]  q2;
  logic [16:0] rem2;
  logic [10:0] blocks3;
  logic [31:0] idat_len;
  logic [13:0] line_len;
  logic [16:0] rem_c, rem_red;
  logic        rem_ge;

  always_comb begin
    line_len = {1'b0, head.width, 1'b0} + {2'b0, head.width} + 14'd1;
    rem_c    = {1'b0, raw_n1[15:0]} + {7'd0, raw_n1[25:16]};
    rem_ge   = rem2 >= BLOCK_MAX;
    rem_red  = rem_ge ? rem2 - BLOCK_MAX : rem2;
  end

  always_ff @(posedge clk) begin
    raw_n1   <= 26'(head.height * line_len);
    raw_n2   <= raw_n1;
    q2       <= raw_n1[25:16];
    rem2     <= rem_c;
    raw_n3   <= raw_n2;
    blocks3  <= {1'b0, q2} + {10'd0, rem_ge} + {10'd0, rem_red != '0};
    idat_len <= {6'd0, raw_n3} + 32'({blocks3, 2'b00} + {2'b0, blocks3}) + 32'd6;
  end

  logic        ld, go;
  logic [7:0]  byte_c;
  logic        do_crc, crc_rst, do_raw, fend;
  logic [15:0] blk_len;
  logic        blk_final;
  logic [31:0] crc_out;
  logic [16:0] lo1, lo2, hi1, hi2;
  logic [7:0]  raw_val;

  assign ld  = !out_valid || !out_stall;
  assign go  = ld && !q_empty;
  assign pop = go && done;

  always_comb begin
    blk_final = {1'b0, raw_rem} <= {10'd0, BLOCK_MAX};
    blk_len   = blk_final ? raw_rem[15:0] : BLOCK_MAX[15:0];
    crc_out   = crc ^ CRC_ONES;

    if (active) begin
      seg_cur = seg;
      idx_cur = idx;
      ri_cur  = ri;
    end else begin
      idx_cur = '0;
      ri_cur  = head.filt ? 2'd0 : 2'd1;
      if (head.hdr)      seg_cur = SG_HDR;
      else if (head.pix) seg_cur = (blk_rem == '0) ? SG_BLK : SG_RAW;
      else               seg_cur = SG_TRL;
    end

    case (ri_cur)
      2'd0:    raw_val = 8'h00;
      2'd1:    raw_val = head.red;
      2'd2:    raw_val = head.green;
      default: raw_val = head.blue;
    endcase

    byte_c  = 8'h00;
    do_crc  = 1'b0;
    crc_rst = 1'b0;
    do_raw  = 1'b0;
    fend    = 1'b0;
    done    = 1'b0;
    seg_nx  = seg_cur;
    idx_nx  = idx_cur + 6'd1;
    ri_nx   = ri_cur;

    unique case (seg_cur)
      SG_HDR: begin
        unique case (idx_cur)
          6'd0:  byte_c = 8'd137;
          6'd1:  byte_c = 8'd80;
          6'd2:  byte_c = 8'd78;
          6'd3:  byte_c = 8'd71;
          6'd4:  byte_c = 8'd13;
          6'd5:  byte_c = 8'd10;
          6'd6:  byte_c = 8'd26;
          6'd7:  byte_c = 8'd10;
          6'd11: byte_c = 8'd13;
          6'd12: byte_c = 8'h49;
          6'd13: byte_c = 8'h48;
          6'd14: byte_c = 8'h44;
          6'd15: byte_c = 8'h52;
          6'd18: byte_c = {4'd0, head.width[11:8]};
          6'd19: byte_c = head.width[7:0];
          6'd22: byte_c = {4'd0, head.height[11:8]};
          6'd23: byte_c = head.height[7:0];
          6'd24: byte_c = 8'd8;
          6'd25: byte_c = 8'd2;
          6'd29: byte_c = crc_out[31:24];
          6'd30: byte_c = crc_out[23:16];
          6'd31: byte_c = crc_out[15:8];
          6'd32: byte_c = crc_out[7:0];
          6'd33: byte_c = idat_len[31:24];
          6'd34: byte_c = idat_len[23:16];
          6'd35: byte_c = idat_len[15:8];
          6'd36: byte_c = idat_len[7:0];
          6'd37: byte_c = 8'h49;
          6'd38: byte_c = 8'h44;
          6'd39: byte_c = 8'h41;
          6'd40: byte_c = 8'h54;
          6'd41: byte_c = 8'h78;
          6'd42: byte_c = 8'h01;
          default: byte_c = 8'h00;
        endcase
        do_crc  = (idx_cur >= 6'd12 && idx_cur <= 6'd28) || idx_cur >= 6'd37;
        crc_rst = (idx_cur == 6'd12) || (idx_cur == 6'd37);
        if (idx_cur == HDR_LAST) begin
          idx_nx = '0;
          // Block count is zero after the header, so a pixel opens a block.
          if (head.pix)      seg_nx = SG_BLK;
          else if (head.trl) seg_nx = SG_TRL;
          else               done   = 1'b1;
        end
      end
      SG_BLK: begin
        do_crc = 1'b1;
        unique case (idx_cur)
          6'd0:    byte_c = {7'd0, blk_final};
          6'd1:    byte_c = blk_len[7:0];
          6'd2:    byte_c = blk_len[15:8];
          6'd3:    byte_c = ~blk_len[7:0];
          default: byte_c = ~blk_len[15:8];
        endcase
        if (idx_cur == BLK_LAST) begin
          idx_nx = '0;
          seg_nx = SG_RAW;
        end
      end
      SG_RAW: begin
        byte_c = raw_val;
        do_crc = 1'b1;
        do_raw = 1'b1;
        idx_nx = '0;
        if (ri_cur == 2'd3) begin
          if (head.trl) seg_nx = SG_TRL;
          else          done   = 1'b1;
        end else begin
          ri_nx  = ri_cur + 2'd1;
          seg_nx = (blk_rem == 16'd1) ? SG_BLK : SG_RAW;
        end
      end
      SG_TRL: begin
        unique case (idx_cur)
          6'd0:  byte_c = adler_high[15:8];
          6'd1:  byte_c = adler_high[7:0];
          6'd2:  byte_c = adler_low[15:8];
          6'd3:  byte_c = adler_low[7:0];
          6'd4:  byte_c = crc_out[31:24];
          6'd5:  byte_c = crc_out[23:16];
          6'd6:  byte_c = crc_out[15:8];
          6'd7:  byte_c = crc_out[7:0];
          6'd12: byte_c = 8'h49;
          6'd13: byte_c = 8'h45;
          6'd14: byte_c = 8'h4E;
          6'd15: byte_c = 8'h44;
          6'd16: byte_c = crc_out[31:24];
          6'd17: byte_c = crc_out[23:16];
          6'd18: byte_c = crc_out[15:8];
          6'd19: byte_c = crc_out[7:0];
          default: byte_c = 8'h00;
        endcase
        do_crc  = idx_cur <= 6'd3 || (idx_cur >= 6'd12 && idx_cur <= 6'd15);
        crc_rst = (idx_cur == 6'd12);
        if (idx_cur == TRL_LAST) begin
          fend = 1'b1;
          done = 1'b1;
        end
      end
      default: done = 1'b1;
    endcase

    lo1 = {1'b0, adler_low} + {9'd0, byte_c};
    lo2 = (lo1 >= ADLER_MOD) ? lo1 - ADLER_MOD : lo1;
    hi1 = {1'b0, adler_high} + lo2;
    hi2 = (hi1 >= ADLER_MOD) ? hi1 - ADLER_MOD : hi1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      seg        <= SG_HDR;
      idx        <= '0;
      ri         <= '0;
      crc        <= CRC_ONES;
      adler_low  <= 16'd1;
      adler_high <= '0;
      raw_rem    <= '0;
      blk_rem    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (ld) out_valid <= !q_empty;
      if (go) begin
        active <= !done;
        seg    <= seg_nx;
        idx    <= idx_nx;
        ri     <= ri_nx;
        if (do_crc) crc <= crc8(crc_rst ? CRC_ONES : crc, byte_c);
        if (seg_cur == SG_HDR && idx_cur == HDR_LAST) begin
          raw_rem    <= raw_n3;
          blk_rem    <= '0;
          adler_low  <= 16'd1;
          adler_high <= '0;
        end
        if (seg_cur == SG_BLK && idx_cur == BLK_LAST) blk_rem <= blk_len;
        if (do_raw) begin
          adler_low  <= lo2[15:0];
          adler_high <= hi2[15:0];
          blk_rem    <= blk_rem - 16'd1;
          raw_rem    <= raw_rem - 26'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_byte <= byte_c;
      run_last <= done;
      file_end <= fend;
    end
  end

endmodule

// ----- design/png_stored_crop_encoder_core.sv -----
// Top level of the cropped stored-deflate PNG encoder.
// A word's first byte is formed from the queue head and registered in the output stage.
// One byte per cycle while out_stall is low and the queue has a word; a cropped pixel gives
// 3 bytes, 4 at a row start; a block header adds 5, the file header 43 and the trailer 20.
// The byte sequencer in the back part sets this rate; the input stalls when the queue fills.
// Reset (rst, synchronous): clears counters, phase, queue and output; registers to defaults.
module png_stored_crop_encoder_core #(
  parameter int FRAME_WIDTH  = 1920,
  parameter int FRAME_HEIGHT = 1080
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  // pixel input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  pixel_blue,
  input  logic [7:0]  pixel_green,
  input  logic [7:0]  pixel_red,
  input  logic        frame_start,
  // PNG byte output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        file_end
);

  logic            accept;
  logic            push, pop, q_full, q_empty;
  pcrop_pkg::cmd_t push_cmd, head;

  // Take a pixel word whenever the queue has room.
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // Front: track raster position, clamp the rectangle, classify each pixel.
  pcrop_front #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .pixel_blue (pixel_blue),
    .pixel_green(pixel_green),
    .pixel_red  (pixel_red),
    .frame_start(frame_start),
    .push       (push),
    .cmd        (push_cmd)
  );

  // Queue: hold classified words so front and back stall independently.
  pcrop_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Back: sequence file bytes through a registered output stage.
  pcrop_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte (out_byte),
    .run_last (run_last),
    .file_end (file_end)
  );

endmodule

// ----- tb/testbench.sv -----
// Testbench of the cropped stored-PNG encoder: pixel stimulus with a bit-exact byte predictor.
module testbench;

  localparam int FW = 1920;
  localparam int FH = 1080;
  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [31:0] CRC_ONES = 32'hffffffff;
  localparam int ADLER_MOD = 65521;
  localparam int BLOCK_MAX = 65535;

  typedef enum logic [1:0] {PH_IDLE, PH_CAPTURE, PH_TRAILER} phase_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       fend;
  } png_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  pixel_blue = '0, pixel_green = '0, pixel_red = '0;
  logic        frame_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        run_last;
  logic        file_end;

  png_stored_crop_encoder_core #(.FRAME_WIDTH(FW), .FRAME_HEIGHT(FH)) dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .pixel_blue(pixel_blue), .pixel_green(pixel_green), .pixel_red(pixel_red),
    .frame_start(frame_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .run_last(run_last), .file_end(file_end)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the registers and the encoder state.
  // ---------------------------------------------------------------------------
  logic [11:0] p_left = 0, p_top = 0, p_width = 1920, p_height = 1080;
  int unsigned col_pos = 0, row_pos = 0;
  int unsigned rect_w = 0, rect_h = 0, rect_l = 0, rect_t = 0;
  int unsigned raw_left = 0, blk_left = 0;
  logic [31:0] run_crc = CRC_ONES;
  int unsigned adl_lo = 1, adl_hi = 0;
  phase_t      phase = PH_IDLE;

  png_word_t   expected_bytes[$];   // bytes still owed by the block
  png_word_t   step_bytes[$];       // bytes of the pixel being predicted
  int          mismatches = 0;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) r = r[0] ? (CRC_POLY ^ (r >> 1)) : (r >> 1);
    return r;
  endfunction

  task automatic put_plain(input logic [31:0] b);
    png_word_t w;
    w.data = b[7:0];
    w.last = 1'b0;
    w.fend = 1'b0;
    step_bytes.push_back(w);
  endtask

  task automatic put_crc(input logic [31:0] b);
    run_crc = crc_byte(run_crc, b[7:0]);
    put_plain(b);
  endtask

  task automatic put_be32(input logic [31:0] v, input bit with_crc);
    for (int s = 24; s >= 0; s -= 8) begin
      if (with_crc) put_crc(v >> s);
      else put_plain(v >> s);
    end
  endtask

  task automatic open_chunk(input logic [31:0] len, input logic [31:0] tag);
    put_be32(len, 1'b0);
    run_crc = CRC_ONES;
    put_be32(tag, 1'b1);
  endtask

  task automatic put_raw(input logic [7:0] b);
    int unsigned len;
    logic [15:0] inv;
    if (blk_left == 0) begin
      len = (raw_left > BLOCK_MAX) ? BLOCK_MAX : raw_left;
      inv = ~len[15:0];
      put_crc((raw_left <= BLOCK_MAX) ? 1 : 0);
      put_crc(len);
      put_crc(len >> 8);
      put_crc(inv);
      put_crc(inv >> 8);
      blk_left = len;
    end
    put_crc(b);
    adl_lo += b;
    if (adl_lo >= ADLER_MOD) adl_lo -= ADLER_MOD;
    adl_hi += adl_lo;
    if (adl_hi >= ADLER_MOD) adl_hi -= ADLER_MOD;
    if (blk_left != 0) blk_left--;
    if (raw_left != 0) raw_left--;
  endtask

  task automatic close_file();
    put_crc(adl_hi >> 8);
    put_crc(adl_hi);
    put_crc(adl_lo >> 8);
    put_crc(adl_lo);
    put_be32(run_crc ^ CRC_ONES, 1'b0);
    open_chunk(0, "IEND");
    put_be32(run_crc ^ CRC_ONES, 1'b0);
    step_bytes[step_bytes.size() - 1].fend = 1'b1;
  endtask

  task automatic open_file();
    logic [7:0]  sig[8] = '{137, 80, 78, 71, 13, 10, 26, 10};
    int unsigned raw_n, blocks;
    raw_n = rect_h * (1 + 3 * rect_w);
    blocks = (raw_n + BLOCK_MAX - 1) / BLOCK_MAX;
    if (blocks == 0) blocks = 1;
    foreach (sig[i]) put_plain(sig[i]);
    open_chunk(13, "IHDR");
    put_be32(rect_w, 1'b1);
    put_be32(rect_h, 1'b1);
    put_crc(8);
    put_crc(2);
    put_crc(0);
    put_crc(0);
    put_crc(0);
    put_be32(run_crc ^ CRC_ONES, 1'b0);
    open_chunk(2 + 5 * blocks + raw_n + 4, "IDAT");
    put_crc(8'h78);
    put_crc(8'h01);
    raw_left = raw_n;
    blk_left = 0;
    adl_lo = 1;
    adl_hi = 0;
  endtask

  // Work out the bytes one accepted pixel word causes and queue them.
  task automatic predict_pixel(input logic [7:0] b, input logic [7:0] g,
                               input logic [7:0] r, input logic fs);
    int unsigned w, h;
    bit header_now;
    header_now = 0;
    step_bytes.delete();
    if (phase == PH_TRAILER) begin
      close_file();
      phase = PH_IDLE;
      if (fs) begin
        col_pos = 0;
        row_pos = 0;
      end
    end else begin
      if (fs) begin
        w = 0;
        h = 0;
        col_pos = 0;
        row_pos = 0;
        if (p_left < FW) w = (p_width < FW - p_left) ? p_width : FW - p_left;
        if (p_top < FH) h = (p_height < FH - p_top) ? p_height : FH - p_top;
        if (w != 0 && h != 0) begin
          rect_l = p_left;
          rect_t = p_top;
          rect_w = w;
          rect_h = h;
          open_file();
          phase = PH_CAPTURE;
          header_now = 1;
        end else begin
          phase = PH_IDLE;
        end
      end
      if (phase == PH_CAPTURE && raw_left != 0 &&
          col_pos >= rect_l && col_pos < rect_l + rect_w &&
          row_pos >= rect_t && row_pos < rect_t + rect_h) begin
        if (col_pos == rect_l) put_raw(8'd0);
        put_raw(r);
        put_raw(g);
        put_raw(b);
        if (raw_left == 0) begin
          if (header_now) begin
            phase = PH_TRAILER;
          end else begin
            close_file();
            phase = PH_IDLE;
          end
        end
      end
    end
    col_pos++;
    if (col_pos >= FW) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= FH) row_pos = 0;
    end
    if (step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].last = 1'b1;
    foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: compare every accepted byte word with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    png_word_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected byte %02h last=%b end=%b", out_byte, run_last, file_end);
      end else begin
        e = expected_bytes.pop_front();
        if (out_byte !== e.data || run_last !== e.last || file_end !== e.fend) begin
          mismatches++;
          if (mismatches <= 10)
            $display("byte mismatch: expected %02h last=%b end=%b, got %02h last=%b end=%b",
                     e.data, e.last, e.fend, out_byte, run_last, file_end);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall on a pattern whose mode changes at random; a long hold-off
  // on request, counted here, lets the block fill up and stall its input.
  // ---------------------------------------------------------------------------
  bit hold_request = 0;

  initial begin
    int mode;
    int hold_count;
    mode = 0;
    hold_count = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall = 1'b1;
        hold_count++;
        if (hold_count >= 400) begin
          hold_request = 0;
          hold_count = 0;
        end
      end else begin
        if ($urandom_range(63) == 0) mode = $urandom_range(3);
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(3) == 0);
          2: out_stall = ($urandom_range(1) == 0);
          default: out_stall = ($urandom_range(7) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps.
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_pixel(input logic [7:0] b, input logic [7:0] g,
                            input logic [7:0] r, input logic fs);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    pixel_blue = b;
    pixel_green = g;
    pixel_red = r;
    frame_start = fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pixel(b, g, r, fs);
  endtask

  task automatic send_random(input logic fs);
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom), fs);
  endtask

  // Stream n pixels with random colors; drop in a frame restart one time in noise_div.
  task automatic stream_pixels(input int n, input int noise_div);
    for (int i = 0; i < n; i++)
      send_random(noise_div > 0 && $urandom_range(noise_div - 1) == 0);
  endtask

  // Hold the input off until the block has delivered every expected byte,
  // then let the latency pass so that an item with no result is finished too.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      pcrop_pkg::REG_LEFT:   p_left = val;
      pcrop_pkg::REG_TOP:    p_top = val;
      pcrop_pkg::REG_WIDTH:  p_width = val;
      default:               p_height = val;
    endcase
  endtask

  // Write the rectangle only once nothing is in flight.
  task automatic set_rect(input logic [11:0] l, input logic [11:0] t,
                          input logic [11:0] w, input logic [11:0] h);
    drain();
    write_reg(pcrop_pkg::REG_LEFT, l);
    write_reg(pcrop_pkg::REG_TOP, t);
    write_reg(pcrop_pkg::REG_WIDTH, w);
    write_reg(pcrop_pkg::REG_HEIGHT, h);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default registers: the full frame; open a file, then abandon it by a restart.
  task automatic test_default_frame();
    send_pixel(8'hff, 8'h00, 8'hff, 1'b1);
    send_pixel(8'h00, 8'hff, 8'h00, 1'b0);
    send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h55, 8'haa, 8'h01, 1'b1);
    send_pixel(8'h80, 8'h7f, 8'hfe, 1'b0);
    drain();
  endtask

  // 1x1 at the origin: the trailer is held for the next word, once with a restart.
  task automatic test_single_pixel();
    set_rect(0, 0, 1, 1);
    send_pixel(8'h12, 8'h34, 8'h56, 1'b1);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    send_pixel(8'hff, 8'hff, 8'hff, 1'b1);
    send_pixel(8'h01, 8'h02, 8'h03, 1'b0);
    stream_pixels(3, 0);
    drain();
  endtask

  // Empty rectangles: zero size or an origin outside the frame emit nothing.
  task automatic test_empty_rect();
    set_rect(0, 0, 0, 4);
    stream_pixels(1, 1);
    stream_pixels(4, 0);
    set_rect(0, 0, 4, 0);
    stream_pixels(1, 1);
    set_rect(1920, 0, 4, 4);
    stream_pixels(1, 1);
    set_rect(4095, 4095, 4095, 4095);
    stream_pixels(1, 1);
    set_rect(0, 1080, 4, 4);
    stream_pixels(1, 1);
    stream_pixels(4, 0);
    drain();
  endtask

  // Small inner rectangle on the first row; hold the receiver off so the input backs up.
  task automatic test_inner_rect();
    set_rect(3, 0, 20, 1);
    send_random(1'b1);
    hold_request = 1;
    stream_pixels(40, 0);
    drain();
  endtask

  // Oversized requests: width and height clamp to the frame edges.
  task automatic test_clamp();
    set_rect(1000, 0, 4095, 4095);
    send_random(1'b1);
    stream_pixels(9, 0);
    set_rect(0, 0, 4095, 1);
    send_random(1'b1);
    stream_pixels(7, 0);
    drain();
  endtask

  // Random small rectangles near the origin, some whole files, some cut short.
  task automatic test_random_files();
    for (int f = 0; f < 14; f++) begin
      set_rect(12'($urandom_range(6)), 12'($urandom_range(1)),
               12'($urandom_range(6, 1)), 12'($urandom_range(2, 1)));
      send_random(1'b1);
      stream_pixels(14, (f % 3 == 0) ? 6 : 0);
      drain();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_default_frame();
    test_single_pixel();
    test_empty_rect();
    test_inner_rect();
    test_clamp();
    test_random_files();
    drain();
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #(8 * 4000000);
    $display("testbench: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
design/pcrop_pkg.sv
design/pcrop_front.sv
design/pcrop_queue.sv
design/pcrop_back.sv
design/png_stored_crop_encoder_core.sv
tb/testbench.sv
